// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL, used by zcm_acc. They compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define ZCM_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a rising clock edge outside reset.
`define ZCM_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    `ZCM_ASSERT(name, clk, rst_n, !(cond), msg)

`else

`define ZCM_ASSERT(name, clk, rst_n, prop, msg)
`define ZCM_ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

// ----- rtl/zcm_pkg.sv -----
`timescale 1ns / 1ps

package zcm_pkg;

    localparam int WORD_BITS     = 32;
    localparam int NUM_OUT_WORDS = 4;

    // Tag size register codes. Code three is taken as a 128-bit tag.
    localparam logic [1:0] TAG_SIZE_32  = 2'd0;
    localparam logic [1:0] TAG_SIZE_64  = 2'd1;
    localparam logic [1:0] TAG_SIZE_128 = 2'd2;

    typedef struct packed {
        logic [WORD_BITS-1:0] keystream_word;
        logic [WORD_BITS-1:0] message_word;
        logic                 last;
        logic [2:0]           last_bytes;
    } t_item;

    typedef logic [NUM_OUT_WORDS-1:0][WORD_BITS-1:0] t_tag_words;

    // Number of tag words for a tag size code, limited to what the block stores.
    function automatic logic [2:0] f_tag_words(input logic [1:0] tag_size,
                                               input logic [2:0] max_words);
        logic [2:0] words;
        unique case (tag_size)
            TAG_SIZE_32:  words = 3'd1;
            TAG_SIZE_64:  words = 3'd2;
            default:      words = 3'd4;
        endcase
        return (words > max_words) ? max_words : words;
    endfunction

endpackage

// ----- rtl/zcm_if.sv -----
`timescale 1ns / 1ps

interface zcm_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] keystream_word;
    logic [31:0] message_word;
    logic        last;
    logic [2:0]  last_bytes;

    modport source(output valid, output keystream_word, output message_word,
                   output last, output last_bytes, input ready);
    modport sink(input valid, input keystream_word, input message_word,
                 input last, input last_bytes, output ready);
endinterface

interface zcm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] tag_word0;
    logic [31:0] tag_word1;
    logic [31:0] tag_word2;
    logic [31:0] tag_word3;

    modport source(output valid, output tag_word0, output tag_word1,
                   output tag_word2, output tag_word3, input ready);
    modport sink(input valid, input tag_word0, input tag_word1,
                 input tag_word2, input tag_word3, output ready);
endinterface

// ----- rtl/zcm_in_stage.sv -----
`timescale 1ns / 1ps

module zcm_in_stage import zcm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    zcm_in_if.sink i_item,
    input  logic   i_pop,
    output logic   o_valid,
    output t_item  o_item
);

    logic  r_valid;
    t_item r_item;
    logic  ready;

    // The register refills in the same cycle that its content moves on.
    assign ready        = !r_valid || i_pop;
    assign i_item.ready = ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_item.valid) begin
            r_item.keystream_word <= i_item.keystream_word;
            r_item.message_word   <= i_item.message_word;
            r_item.last           <= i_item.last;
            r_item.last_bytes     <= i_item.last_bytes;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- rtl/zcm_acc.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module zcm_acc import zcm_pkg::*; #(
    parameter int MAX_TAG_WORDS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    input  logic       i_item_valid,
    input  t_item      i_item,
    input  logic       i_out_free,
    output logic       o_step,
    output logic       o_push,
    output t_tag_words o_tag
);

    localparam int W        = MAX_TAG_WORDS;
    localparam int WIN_BITS = W * WORD_BITS;
    localparam int EXT_BITS = (W + 1) * WORD_BITS;
    localparam int CNT_W    = $clog2(2 * W + 1);

    logic [1:0]                   r_tag_size;
    logic [W-1:0][WORD_BITS-1:0]  r_tag;
    logic [CNT_W-1:0]             r_cnt;
    logic [WIN_BITS-1:0]          r_win;

    logic [2:0]                   t;
    logic [3:0]                   t2;
    logic                         preload;
    logic                         emit;
    logic [EXT_BITS-1:0]          ext;
    logic [EXT_BITS-1:0]          al;
    logic [EXT_BITS-1:0]          fin_sh;
    logic [2:0]                   lb;
    logic [5:0]                   nbits;
    logic [WORD_BITS-1:0]         m_eff;
    logic [W-1:0][WORD_BITS-1:0]  n_tag;

    assign t       = f_tag_words(r_tag_size, 3'(W));
    assign t2      = {t, 1'b0};
    assign preload = 4'(r_cnt) < t2;
    assign emit    = !preload && i_item.last;
    assign o_step  = i_item_valid && (!emit || i_out_free);
    assign o_push  = o_step && emit;

    // Stream view for the current message word: the last T stored keystream
    // words, then the new word, left-aligned so tag word q starts at word q.
    assign ext    = {r_win, i_item.keystream_word};
    assign al     = ext << {3'(W) - t, 5'd0};
    assign lb     = (i_item.last_bytes > 3'd4) ? 3'd4 : i_item.last_bytes;
    assign nbits  = i_item.last ? {lb, 3'b000} : 6'd32;
    assign fin_sh = al << nbits;

    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            m_eff[WORD_BITS-1-b] = i_item.message_word[WORD_BITS-1-b] && (6'(b) < nbits);
        end
    end

    // Each set message bit selects a window shifted by its bit position; the
    // whole word folds into one XOR tree per tag bit.
    always_comb begin
        logic [WORD_BITS-1:0] acc;
        for (int q = 0; q < W; q++) begin
            acc = r_tag[q];
            for (int b = 0; b < WORD_BITS; b++) begin
                if (m_eff[WORD_BITS-1-b]) begin
                    acc = acc ^ al[EXT_BITS-1-q*WORD_BITS-b -: WORD_BITS];
                end
            end
            if (i_item.last) begin
                acc = acc ^ fin_sh[EXT_BITS-1-q*WORD_BITS -: WORD_BITS];
            end
            n_tag[q] = (3'(q) < t) ? acc : '0;
        end
    end

    for (genvar g = 0; g < NUM_OUT_WORDS; g++) begin : g_out
        if (g < W) begin : g_word
            assign o_tag[g] = n_tag[g];
        end else begin : g_zero
            assign o_tag[g] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_size <= TAG_SIZE_128;
            r_tag      <= '0;
            r_cnt      <= '0;
        end else if (i_cfg_we) begin
            r_tag_size <= i_cfg_wdata;
            r_tag      <= '0;
            r_cnt      <= '0;
        end else if (o_step) begin
            if (preload) begin
                // The first T preload words are the initial tag.
                r_cnt <= r_cnt + CNT_W'(1);
                for (int q = 0; q < W; q++) begin
                    if (3'(q) < t && 4'(r_cnt) == 4'(q)) begin
                        r_tag[q] <= i_item.keystream_word;
                    end
                end
            end else if (emit) begin
                r_tag <= '0;
                r_cnt <= '0;
            end else begin
                r_tag <= n_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_step) begin
            r_win <= ext[WIN_BITS-1:0];
        end
    end

    `ZCM_ASSERT(a_restart_after_tag, i_clk, i_rst_n, o_push |=> (r_cnt == '0), "preload count not cleared after tag")
    `ZCM_ASSERT_NEVER(a_cnt_bound, i_clk, i_rst_n, 4'(r_cnt) > t2, "preload count beyond twice the tag words")
    `ZCM_ASSERT(a_short_tag_zero, i_clk, i_rst_n, (o_push && t == 3'd1) |-> (o_tag[1] == '0 && o_tag[3] == '0), "unused tag words not zero")

endmodule

// ----- rtl/zcm_out_stage.sv -----
`timescale 1ns / 1ps

module zcm_out_stage import zcm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_tag_words i_tag,
    output logic       o_free,
    zcm_out_if.source  o_tag
);

    logic       r_valid;
    t_tag_words r_tag;

    assign o_free = !r_valid || o_tag.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_tag <= i_tag;
        end
    end

    assign o_tag.valid     = r_valid;
    assign o_tag.tag_word0 = r_tag[0];
    assign o_tag.tag_word1 = r_tag[1];
    assign o_tag.tag_word2 = r_tag[2];
    assign o_tag.tag_word3 = r_tag[3];

endmodule

// ----- rtl/stream_cipher_mac_tag_accumulator_unit.sv -----
`timescale 1ns / 1ps

// MAC tag accumulator for a ZUC-256 style integrity check, fed with keystream
// words from an external generator. Per message, send 2T keystream-only
// transactions (T = 1, 2 or 4 tag words by tag size), then one transaction per
// message word with the next keystream word; the one marked last carries the
// valid byte count and produces one tag transaction (words beyond T read 0).
// The block takes one transaction per clock: each goes through an input
// register and XOR accumulation into the tag register; the last one of a
// message writes the tag into the output register. The only stall is a full
// output register. Write the tag size only while idle; a write starts a new
// message.

module stream_cipher_mac_tag_accumulator_unit import zcm_pkg::*; #(
    parameter int MAX_TAG_WORDS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    zcm_in_if.sink     i_item,
    zcm_out_if.source  o_tag
);

    logic       item_valid;
    t_item      item;
    logic       step;
    logic       push;
    logic       out_free;
    t_tag_words tag;

    zcm_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_pop   (step),
        .o_valid (item_valid),
        .o_item  (item)
    );

    zcm_acc #(
        .MAX_TAG_WORDS (MAX_TAG_WORDS)
    ) u_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item_valid (item_valid),
        .i_item       (item),
        .i_out_free   (out_free),
        .o_step       (step),
        .o_push       (push),
        .o_tag        (tag)
    );

    zcm_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tag   (tag),
        .o_free  (out_free),
        .o_tag   (o_tag)
    );

endmodule

// ----- tb/sv/zcm_tag_checker.sv -----
`timescale 1ns / 1ps

module zcm_tag_checker import zcm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    zcm_in_if          i_item,
    zcm_out_if         i_tag,
    output int         o_fail_count,
    output int         o_tags_due
);

    logic [1:0]  tag_size_q;
    logic [31:0] tag_acc [0:3];
    logic [31:0] ks_hist [0:7];
    // Keystream history plus the word that arrives with the current transaction.
    logic [31:0] ks_ext [0:8];
    int unsigned preload_n;
    int          fail_n;
    t_tag_words  tags_due[$];
    t_tag_words  got_tag;
    t_tag_words  want_tag;

    function automatic int unsigned tag_len(input logic [1:0] size);
        case (size)
            TAG_SIZE_32: return 1;
            TAG_SIZE_64: return 2;
            default:     return 4;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_n++;
        $display("[%0t] %s: got %08h, expected %08h", $time, what, got, want);
    endtask

    task automatic restart_message();
        for (int q = 0; q < 4; q++) tag_acc[q] = '0;
        preload_n = 0;
    endtask

    task automatic shift_keystream(input logic [31:0] ks);
        for (int k = 0; k < 7; k++) ks_hist[k] = ks_hist[k + 1];
        ks_hist[7] = ks;
    endtask

    // XOR the t-word keystream window starting at word base, bit off into the tag.
    task automatic fold_window(input int unsigned base, input int unsigned off,
                               input int unsigned t);
        int unsigned a;
        int unsigned b;
        logic [31:0] w;
        for (int unsigned q = 0; q < t; q++) begin
            a = (base + q > 8) ? 8 : base + q;
            b = (a + 1 > 8) ? 8 : a + 1;
            if (off == 0) begin
                w = ks_ext[a];
            end else begin
                w = (ks_ext[a] << off) | (ks_ext[b] >> (32 - off));
            end
            tag_acc[q] ^= w;
        end
    endtask

    task automatic absorb_item(input logic [31:0] ks, input logic [31:0] msg,
                               input logic last, input logic [2:0] nbytes);
        int unsigned t;
        int unsigned base;
        int unsigned nbits;
        t_tag_words  tag;
        t = tag_len(tag_size_q);
        if (preload_n < 2 * t) begin
            shift_keystream(ks);
            preload_n++;
            if (preload_n == 2 * t) begin
                for (int unsigned q = 0; q < t; q++) tag_acc[q] = ks_hist[8 - 2 * t + q];
            end
            return;
        end
        for (int k = 0; k < 8; k++) ks_ext[k] = ks_hist[k];
        ks_ext[8] = ks;
        base = 8 - t;
        if (last) begin
            nbits = 8 * ((nbytes > 4) ? 4 : nbytes);
        end else begin
            nbits = 32;
        end
        for (int unsigned b = 0; b < nbits; b++) begin
            if (msg[31 - b]) fold_window(base, b, t);
        end
        shift_keystream(ks);
        if (!last) return;
        // A full final word moves the closing window to the next keystream word.
        if (nbits == 32) begin
            fold_window(base + 1, 0, t);
        end else begin
            fold_window(base, nbits, t);
        end
        for (int q = 0; q < 4; q++) tag[q] = (q < t) ? tag_acc[q] : '0;
        tags_due.push_back(tag);
        restart_message();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tag_size_q = TAG_SIZE_128;
            for (int k = 0; k < 8; k++) ks_hist[k] = '0;
            restart_message();
            tags_due.delete();
            fail_n = 0;
        end else begin
            if (i_tag.valid && i_tag.ready) begin
                got_tag = {i_tag.tag_word3, i_tag.tag_word2, i_tag.tag_word1,
                           i_tag.tag_word0};
                if (tags_due.size() == 0) begin
                    report_mismatch("tag transaction with none expected", got_tag[0], '0);
                end else begin
                    want_tag = tags_due.pop_front();
                    for (int q = 0; q < 4; q++) begin
                        if (got_tag[q] !== want_tag[q]) begin
                            report_mismatch($sformatf("tag_word%0d", q), got_tag[q],
                                            want_tag[q]);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                tag_size_q = i_cfg_wdata;
                restart_message();
            end
            if (i_item.valid && i_item.ready) begin
                absorb_item(i_item.keystream_word, i_item.message_word, i_item.last,
                            i_item.last_bytes);
            end
        end
        o_fail_count <= fail_n;
        o_tags_due   <= tags_due.size();
    end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import zcm_pkg::*;

    localparam logic [1:0] TAG_SIZE_CODE3 = 2'd3;

    localparam int PAT_ZERO   = 0;
    localparam int PAT_ONES   = 1;
    localparam int PAT_RAND   = 2;
    localparam int PAT_WALK   = 3;
    localparam int PAT_SPARSE = 4;

    localparam int ITEM_TARGET = 1800;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_wdata;
    int         fail_count;
    int         tags_due;
    int         items_sent;
    logic       calm;
    logic [1:0] cur_size;

    zcm_in_if  item_if ();
    zcm_out_if tag_if ();

    stream_cipher_mac_tag_accumulator_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_item     (item_if),
        .o_tag      (tag_if)
    );

    zcm_tag_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item_if),
        .i_tag       (tag_if),
        .o_fail_count(fail_count),
        .o_tags_due  (tags_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("stream_cipher_mac_tag_accumulator_unit test failed");
        $finish;
    end

    // The tag sink stalls at random except during the calm stretch.
    always @(posedge i_clk) begin
        tag_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 29);
    end

    function automatic logic [31:0] pattern_word(input int pat, input int idx);
        case (pat)
            PAT_ZERO:   return 32'h0;
            PAT_ONES:   return 32'hFFFF_FFFF;
            PAT_WALK:   return 32'h8000_0000 >> (idx % 32);
            PAT_SPARSE: return 32'h1 << $urandom_range(31);
            default:    return $urandom;
        endcase
    endfunction

    task automatic idle_gaps();
        while (!calm && $urandom_range(99) < 29) begin
            item_if.valid          <= 1'b0;
            item_if.keystream_word <= $urandom;
            item_if.message_word   <= $urandom;
            item_if.last           <= 1'($urandom_range(1));
            item_if.last_bytes     <= 3'($urandom_range(7));
            @(posedge i_clk);
        end
    endtask

    task automatic send_item(input logic [31:0] ks, input logic [31:0] msg,
                             input logic last, input logic [2:0] nbytes);
        idle_gaps();
        item_if.valid          <= 1'b1;
        item_if.keystream_word <= ks;
        item_if.message_word   <= msg;
        item_if.last           <= last;
        item_if.last_bytes     <= nbytes;
        do @(posedge i_clk); while (item_if.ready != 1'b1);
        items_sent++;
        calm <= (items_sent >= 800 && items_sent < 1100);
    endtask

    task automatic stop_items();
        item_if.valid <= 1'b0;
    endtask

    // Only written with no transaction in flight; the write restarts the message.
    task automatic write_tag_size(input logic [1:0] size);
        stop_items();
        do @(posedge i_clk); while (tags_due != 0);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= size;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_size = size;
    endtask

    task automatic run_message(input int words, input logic [2:0] nbytes, input int pat);
        int t;
        t = (cur_size == TAG_SIZE_32) ? 1 : (cur_size == TAG_SIZE_64) ? 2 : 4;
        // Preload transactions carry filler, not message data, in the message fields.
        for (int p = 0; p < 2 * t; p++) begin
            send_item(pattern_word(pat, p),
                      (pat == PAT_RAND) ? $urandom : pattern_word(pat, p),
                      (pat == PAT_ONES) ? 1'b1 : 1'($urandom_range(1)),
                      3'($urandom_range(7)));
        end
        for (int j = 0; j < words; j++) begin
            send_item(pattern_word(pat, 2 * t + j), pattern_word(pat, j),
                      j == words - 1, (j == words - 1) ? nbytes : 3'($urandom_range(7)));
        end
    endtask

    task automatic run_partial(input int n);
        for (int k = 0; k < n; k++) begin
            send_item($urandom, $urandom, 1'b0, 3'($urandom_range(7)));
        end
    endtask

    initial begin
        int         phase;
        int         n_msgs;
        int         words;
        int         pat;
        logic [2:0] nbytes;
        logic [1:0] size;

        i_rst_n                <= 1'b0;
        i_cfg_we               <= 1'b0;
        i_cfg_wdata            <= TAG_SIZE_128;
        item_if.valid          <= 1'b0;
        item_if.keystream_word <= '0;
        item_if.message_word   <= '0;
        item_if.last           <= 1'b0;
        item_if.last_bytes     <= 3'd0;
        calm                   <= 1'b0;
        cur_size   = TAG_SIZE_128;
        items_sent = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: reset tag size, byte counts of zero and above four,
        // and a tag size write in the middle of a preload.
        run_message(1, 3'd4, PAT_ONES);
        write_tag_size(TAG_SIZE_32);
        run_message(2, 3'd0, PAT_WALK);
        run_message(1, 3'd7, PAT_RAND);
        write_tag_size(TAG_SIZE_64);
        run_message(1, 3'd1, PAT_ZERO);
        write_tag_size(TAG_SIZE_CODE3);
        run_partial(3);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            size = (phase < 4) ? 2'(phase) : 2'($urandom_range(3));
            write_tag_size(size);
            phase++;
            n_msgs = $urandom_range(3, 10);
            for (int m = 0; m < n_msgs; m++) begin
                words  = ($urandom_range(9) == 0) ? $urandom_range(6, 24)
                                                  : $urandom_range(1, 5);
                nbytes = ($urandom_range(9) < 7) ? 3'($urandom_range(1, 4))
                                                 : 3'($urandom_range(7));
                pat    = ($urandom_range(7) == 0) ? $urandom_range(PAT_ZERO, PAT_SPARSE)
                                                  : PAT_RAND;
                run_message(words, nbytes, pat);
            end
            // Sometimes leave a message unfinished; the next write drops it.
            if ($urandom_range(3) == 0) run_partial($urandom_range(1, 11));
        end

        stop_items();
        do @(posedge i_clk); while (tags_due != 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("stream_cipher_mac_tag_accumulator_unit test passed");
        end else begin
            $display("stream_cipher_mac_tag_accumulator_unit test failed");
        end
        $finish;
    end

endmodule
